FILE: rtl/mgil_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mgil_pkg
// Shared types and codes for the member-to-group index lookup: item
// commands, configuration register indexes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package mgil_pkg;

    // Input item commands
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_GROUP_COUNT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FUZZ_CHECK  = 2'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_CHECK
    } mgil_state_t;

    // Controller -> datapath
    typedef struct packed {
        logic load;   // write one table entry
        logic query;  // latch id, issue first probe
        logic step;   // consume probe read data, issue next probe
        logic emit;   // load result into output register
    } mgil_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic count_zero;   // no entries covered, skip the search
        logic search_done;  // span reaches zero after this step
    } mgil_status_t;

endpackage

FILE: rtl/member_to_group_index_lookup.sv
// Load beat: writes one table entry and gives no result; the next beat follows at once.
// Query beat: accepted while idle, then one search probe per cycle (at most
// ceil(log2(group_count + 1)) probes, 13 for 4096 groups), then the length check, which
// waits until the output register is free; one query at a time.
// The single read port of the start and length tables sets the probe rate.
// Reset clears control and configuration; table contents are undefined until loaded.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// member_to_group_index_lookup
// Finds the last group whose start is at most a member id by a halving search
// over a loaded, sorted table, with an optional check against group length.
// ----------------------------------------------------------------------------
module member_to_group_index_lookup
#(
    parameter int unsigned MAX_GROUPS = 4096,
    parameter int unsigned ID_WIDTH   = 31,
    parameter int unsigned IDX_W      = $clog2(MAX_GROUPS),
    parameter int unsigned CNT_W      = IDX_W + 1
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write_en,
    input  logic [mgil_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [CNT_W-1:0]                  cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              command,
    input  logic [IDX_W-1:0]                  entry_index,
    input  logic [ID_WIDTH-1:0]               entry_start,
    input  logic [ID_WIDTH-1:0]               entry_length,
    input  logic [ID_WIDTH-1:0]               member_id,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [CNT_W-1:0]           group_index
);
    import mgil_pkg::*;

    mgil_cmd_t    cmd;
    mgil_status_t status;

    mgil_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .command   (command),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    mgil_dp
    #(
        .MAX_GROUPS (MAX_GROUPS),
        .ID_WIDTH   (ID_WIDTH),
        .IDX_W      (IDX_W),
        .CNT_W      (CNT_W)
    )
    u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .entry_index  (entry_index),
        .entry_start  (entry_start),
        .entry_length (entry_length),
        .member_id    (member_id),
        .cmd          (cmd),
        .status       (status),
        .group_index  (group_index)
    );

endmodule

FILE: rtl/mgil_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mgil_ctrl
// Sequencer for the lookup: takes one beat at a time, walks the halving
// search one probe per cycle, runs the length check and hands the result to
// the output register.
// ----------------------------------------------------------------------------
module mgil_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  command,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  mgil_pkg::mgil_status_t status,
    output mgil_pkg::mgil_cmd_t    cmd
);
    import mgil_pkg::*;

    mgil_state_t state_reg;
    mgil_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = (state_reg == ST_IDLE);
        accept     = in_valid && in_ready;
        cmd        = '0;
        cmd.load   = accept && (command == CMD_LOAD);
        cmd.query  = accept && (command == CMD_QUERY);

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.query)
                begin
                    state_next = status.count_zero ? ST_CHECK : ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                cmd.step = 1'b1;
                if (status.search_done)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                // hold until the output register is free
                cmd.emit = !out_valid_reg || out_ready;
                if (cmd.emit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

FILE: rtl/mgil_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mgil_dp
// Datapath of the lookup: configuration registers, start and length tables,
// the lower-bound search registers, the length check and the result
// register.
// ----------------------------------------------------------------------------
module mgil_dp
#(
    parameter int unsigned MAX_GROUPS = 4096,
    parameter int unsigned ID_WIDTH   = 31,
    parameter int unsigned IDX_W      = $clog2(MAX_GROUPS),
    parameter int unsigned CNT_W      = IDX_W + 1
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write_en,
    input  logic [mgil_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [CNT_W-1:0]                    cfg_data,
    input  logic [IDX_W-1:0]                    entry_index,
    input  logic [ID_WIDTH-1:0]                 entry_start,
    input  logic [ID_WIDTH-1:0]                 entry_length,
    input  logic [ID_WIDTH-1:0]                 member_id,
    input  mgil_pkg::mgil_cmd_t                 cmd,
    output mgil_pkg::mgil_status_t              status,
    output logic signed [CNT_W-1:0]             group_index
);
    import mgil_pkg::*;

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_GROUPS);

    // tables
    logic [ID_WIDTH-1:0] start_mem [MAX_GROUPS];
    logic [ID_WIDTH-1:0] len_mem   [MAX_GROUPS];
    logic [ID_WIDTH-1:0] st_rd_reg;
    logic [ID_WIDTH-1:0] ln_rd_reg;

    // configuration
    logic [CNT_W-1:0]    count_reg;
    logic                fuzz_reg;
    logic [CNT_W-1:0]    count_clamped;

    // search
    logic [ID_WIDTH-1:0] id_reg;
    logic [ID_WIDTH-1:0] id_next;
    logic [CNT_W-1:0]    first_reg;
    logic [CNT_W-1:0]    first_next;
    logic [CNT_W-1:0]    span_reg;
    logic [CNT_W-1:0]    span_next;
    logic [CNT_W-1:0]    half;
    logic [CNT_W-1:0]    probe_sum;
    logic [IDX_W-1:0]    probe_reg;
    logic [IDX_W-1:0]    rd_addr;
    logic                rd_en;
    logic                le;

    // last probe that moved right: the candidate group
    logic                hit_reg;
    logic                hit_next;
    logic [ID_WIDTH-1:0] hit_start_reg;
    logic [ID_WIDTH-1:0] hit_len_reg;
    logic [IDX_W-1:0]    hit_idx_reg;

    logic [ID_WIDTH-1:0] offset;
    logic                match;
    logic [CNT_W-1:0]    result;
    logic [CNT_W-1:0]    out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            fuzz_reg  <= 1'b0;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_GROUP_COUNT: count_reg <= cfg_data;
                REG_FUZZ_CHECK:  fuzz_reg  <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    assign count_clamped     = (count_reg > MAX_CNT) ? MAX_CNT : count_reg;
    assign status.count_zero = (count_clamped == '0);

    // next search state
    always_comb
    begin
        half       = span_reg >> 1;
        le         = (st_rd_reg <= id_reg);
        first_next = first_reg;
        span_next  = span_reg;
        id_next    = id_reg;
        hit_next   = hit_reg;
        if (cmd.query)
        begin
            first_next = '0;
            span_next  = count_clamped;
            id_next    = member_id;
            hit_next   = 1'b0;
        end
        else if (cmd.step)
        begin
            if (le)
            begin
                first_next = {1'b0, probe_reg} + CNT_W'(1);
                span_next  = span_reg - half - CNT_W'(1);
                hit_next   = 1'b1;
            end
            else
            begin
                span_next = half;
            end
        end
        probe_sum = first_next + (span_next >> 1);
        rd_addr   = probe_sum[IDX_W-1:0];
        rd_en     = (cmd.query || cmd.step) && (span_next != '0);
    end

    assign status.search_done = (span_next == '0);

    always_ff @(posedge clk)
    begin
        first_reg <= first_next;
        span_reg  <= span_next;
        id_reg    <= id_next;
        if (rd_en)
        begin
            probe_reg <= rd_addr;
        end
        if (cmd.step && le)
        begin
            hit_start_reg <= st_rd_reg;
            hit_len_reg   <= ln_rd_reg;
            hit_idx_reg   <= probe_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else
        begin
            hit_reg <= hit_next;
        end
    end

    // table write port; drop loads to slots past the table
    always_ff @(posedge clk)
    begin
        if (cmd.load && ({1'b0, entry_index} < MAX_CNT))
        begin
            start_mem[entry_index] <= entry_start;
            len_mem[entry_index]   <= entry_length;
        end
    end

    // table read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            st_rd_reg <= start_mem[rd_addr];
            ln_rd_reg <= len_mem[rd_addr];
        end
    end

    // length check: the search guarantees start <= id, so the offset never wraps
    always_comb
    begin
        offset = id_reg - hit_start_reg;
        match  = hit_reg && (!fuzz_reg || (offset < hit_len_reg));
        result = match ? {1'b0, hit_idx_reg} : '1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_data_reg <= result;
        end
    end

    assign group_index = out_data_reg;

endmodule

FILE: rtl/mgil_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mgil_checker
// Port-level checks for the lookup, bound to the top level.
// ----------------------------------------------------------------------------
module mgil_checker
#(
    parameter int unsigned CNT_W = 13
)
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             command,
    input logic             out_valid,
    input logic             out_ready,
    input logic [CNT_W-1:0] group_index
);
    import mgil_pkg::*;

    // hold a stalled result beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(group_index))
        else $error("result beat dropped or changed while stalled");

    // a query keeps the block busy for at least the next cycle
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (command == CMD_QUERY) |=> !in_ready)
        else $error("input taken during a search");

    // a load never produces a result
    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (command == CMD_LOAD) |=> !$rose(out_valid))
        else $error("result raised after a load beat");

    // results appear only at the end of a query
    a_rise_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result raised while idle");

    // result is a table index or the no-match code
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (group_index[CNT_W-1] == 1'b0) || (&group_index))
        else $error("result outside index range");

endmodule

bind member_to_group_index_lookup mgil_checker
#(
    .CNT_W (CNT_W)
)
u_mgil_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .command     (command),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .group_index (group_index)
);

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for member_to_group_index_lookup. Loads group tables,
// sets group count and fuzz check, and sends query beats whose group index is
// predicted from a copy of the table kept here. Both handshakes idle at
// random; the receiver also holds off for a long stretch so the block stalls.
// ----------------------------------------------------------------------------
module tb;

    import mgil_pkg::*;

    localparam int unsigned GROUPS       = 4096;
    localparam int unsigned LOADED       = 1024;
    localparam int unsigned ID_W         = 31;
    localparam int unsigned IDX_W        = 12;
    localparam int unsigned CNT_W        = 13;
    localparam longint      ID_MAX       = 64'h7FFF_FFFF;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam int unsigned CYCLE_LIMIT  = 500000;

    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   cfg_write_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [CNT_W-1:0]       cfg_data     = '0;
    logic                   in_valid     = 1'b0;
    logic                   in_ready;
    logic                   command      = CMD_LOAD;
    logic [IDX_W-1:0]       entry_index  = '0;
    logic [ID_W-1:0]        entry_start  = '0;
    logic [ID_W-1:0]        entry_length = '0;
    logic [ID_W-1:0]        member_id    = '0;
    logic                   out_valid;
    logic                   out_ready    = 1'b0;
    logic signed [CNT_W-1:0] group_index;

    member_to_group_index_lookup dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .command      (command),
        .entry_index  (entry_index),
        .entry_start  (entry_start),
        .entry_length (entry_length),
        .member_id    (member_id),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .group_index  (group_index)
    );

    // Shadow copy of the table and registers
    logic [ID_W-1:0]  start_tab [GROUPS];
    logic [ID_W-1:0]  len_tab   [GROUPS];
    int unsigned      cur_count = 0;
    logic             cur_fuzz  = 1'b0;

    logic [CNT_W-1:0] expected_groups [$];
    int unsigned      mismatch_count = 0;
    int unsigned      cycle_count    = 0;
    logic             idle_on        = 1'b1;
    int unsigned      hold_asked     = 0;
    int unsigned      hold_taken     = 0;
    int unsigned      hold_left      = 0;

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    function automatic int unsigned covered();
        return (cur_count > GROUPS) ? GROUPS : cur_count;
    endfunction

    // Last covered group whose start is at most id, by the halving search, then the length check
    function automatic logic [CNT_W-1:0] predict_group(input logic [ID_W-1:0] id);
        int unsigned first;
        int unsigned span;
        int unsigned half;
        int unsigned probe;
        logic [CNT_W-1:0] res;
        first = 0;
        span  = covered();
        res   = '1;
        while (span > 0)
        begin
            half  = span / 2;
            probe = first + half;
            if (probe < GROUPS && start_tab[probe] <= id)
            begin
                first = probe + 1;
                span  = span - (half + 1);
            end
            else
            begin
                span = half;
            end
        end
        if (first > 0)
        begin
            // id is at or past the start here, so the difference never wraps
            if (!cur_fuzz || (id - start_tab[first-1]) < len_tab[first-1])
                res = CNT_W'(first - 1);
        end
        return res;
    endfunction

    function automatic logic [ID_W-1:0] pick_length();
        case ($urandom_range(4))
            0:       return '0;
            1:       return ID_W'(1);
            2:       return ID_W'($urandom_range(1, 1 << 20));
            3:       return ID_W'($urandom);
            default: return ID_W'($urandom_range(1, 64));
        endcase
    endfunction

    // Mostly ids at or around a loaded, covered start, some fully random
    function automatic logic [ID_W-1:0] pick_member();
        int unsigned s;
        logic [ID_W-1:0] off;
        if (covered() == 0 || $urandom_range(99) < 15)
            return ID_W'($urandom);
        s = $urandom_range(((covered() < LOADED) ? covered() : LOADED) - 1);
        case ($urandom_range(4))
            0:       off = '0;
            1:       off = '1;
            2:       off = len_tab[s] - 1'b1;
            3:       off = len_tab[s];
            default: off = ID_W'($urandom_range(3));
        endcase
        return start_tab[s] + off;
    endfunction

    task automatic report_mismatch(input string what, input logic [CNT_W-1:0] exp_val,
                                   input logic [CNT_W-1:0] got_val);
        $display("tb: mismatch at cycle %0d: %s (expected %0d, got %0d)", cycle_count, what,
                 $signed(exp_val), $signed(got_val));
        mismatch_count++;
    endtask

    // Result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_groups.size() == 0)
                report_mismatch("result beat with nothing expected", '1, group_index);
            else if (expected_groups[0] !== group_index)
                report_mismatch("group_index", expected_groups.pop_front(), group_index);
            else
                void'(expected_groups.pop_front());
        end
    end

    // Receiver: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_taken != hold_asked)
        begin
            hold_taken <= hold_asked;
            hold_left  <= HOLD_CYCLES;
            out_ready  <= 1'b0;
        end
        else
        begin
            out_ready <= !idle_on || ($urandom_range(99) >= 12);
        end
    end

    task automatic send_beat(input logic cmd, input logic [IDX_W-1:0] idx,
                             input logic [ID_W-1:0] st, input logic [ID_W-1:0] len,
                             input logic [ID_W-1:0] id);
        while (idle_on && $urandom_range(99) < 12)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        command      <= cmd;
        entry_index  <= idx;
        entry_start  <= st;
        entry_length <= len;
        member_id    <= id;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (cmd == CMD_LOAD)
        begin
            start_tab[idx] = st;
            len_tab[idx]   = len;
        end
        else
        begin
            expected_groups = {expected_groups, predict_group(id)};
        end
    endtask

    task automatic send_load(input logic [IDX_W-1:0] idx, input logic [ID_W-1:0] st,
                             input logic [ID_W-1:0] len);
        send_beat(CMD_LOAD, idx, st, len, ID_W'($urandom));
    endtask

    // Past the loaded slots only the guard slots hold the largest start; keep ids
    // below it there so every search turns back into the loaded range
    task automatic send_query(input logic [ID_W-1:0] id);
        logic [ID_W-1:0] q_id;
        q_id = (covered() > LOADED && id == '1) ? id - 1'b1 : id;
        send_beat(CMD_QUERY, IDX_W'($urandom), ID_W'($urandom), ID_W'($urandom), q_id);
    endtask

    // Drop valid and wait until every result is back, then let the block settle
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_groups.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CNT_W-1:0] val);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= val;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        @(posedge clk);
        if (idx == REG_GROUP_COUNT)
            cur_count = val;
        else if (idx == REG_FUZZ_CHECK)
            cur_fuzz = val[0];
    endtask

    // Reset values: no groups covered, so every query misses
    task automatic test_reset_state();
        send_query('0);
        send_query('1);
        send_query(ID_W'($urandom));
        wait_drained();
    endtask

    task automatic test_small_table();
        send_load(0, ID_W'(10), ID_W'(5));
        send_load(1, ID_W'(20), '0);
        send_load(2, ID_W'(30), '1);
        send_load(3, ID_W'(32'h7FFF_FFF0), ID_W'(16));
        wait_drained();
        write_reg(REG_GROUP_COUNT, CNT_W'(4));
        write_reg(REG_FUZZ_CHECK, CNT_W'(0));
        send_query('0);                   // below the first start
        send_query(ID_W'(9));
        send_query(ID_W'(10));
        send_query(ID_W'(15));
        send_query(ID_W'(29));
        send_query('1);
        wait_drained();
        write_reg(REG_FUZZ_CHECK, CNT_W'(1));
        send_query(ID_W'(14));
        send_query(ID_W'(15));            // one past the last member
        send_query(ID_W'(20));            // zero-length group
        send_query(ID_W'(30));
        send_query('1);
        send_query('0);
        wait_drained();
        write_reg(REG_GROUP_COUNT, CNT_W'(1));
        send_query('1);
        send_query(ID_W'(12));
        wait_drained();
    endtask

    // Break the ordering and follow wherever the search lands
    task automatic test_unsorted();
        send_load(1, '1, ID_W'(3));
        wait_drained();
        write_reg(REG_GROUP_COUNT, CNT_W'(4));
        write_reg(REG_FUZZ_CHECK, CNT_W'(0));
        send_query(ID_W'(25));
        send_query('1);
        send_query(ID_W'(35));
        wait_drained();
    endtask

    // Low slots loaded and sorted, with no idling on either side; the slots that a
    // full-table search probes on its way down to them hold the largest start
    task automatic test_full_table();
        idle_on <= 1'b0;
        for (int i = 0; i < LOADED; i++)
            send_load(IDX_W'(i), ID_W'((i << 21) | $urandom_range((1 << 21) - 1)), pick_length());
        for (int p = GROUPS / 2; p >= LOADED; p = p / 2)
            send_load(IDX_W'(p), '1, pick_length());
        wait_drained();
        write_reg(REG_GROUP_COUNT, CNT_W'(GROUPS));
        write_reg(REG_FUZZ_CHECK, CNT_W'(0));
        repeat (80) send_query(pick_member());
        send_query('0);
        send_query('1);
        wait_drained();
        write_reg(REG_FUZZ_CHECK, CNT_W'(1));
        repeat (80) send_query(pick_member());
        wait_drained();
        write_reg(REG_GROUP_COUNT, '1);   // clamps to the table size
        repeat (40) send_query(pick_member());
        wait_drained();
        idle_on <= 1'b1;
    endtask

    // Receiver holds off while the sender keeps offering beats
    task automatic test_hold_off();
        hold_asked <= hold_asked + 1;
        repeat (40) send_query(pick_member());
        wait_drained();
    endtask

    task automatic test_random();
        int unsigned s;
        longint lo;
        longint hi;
        for (int phase = 0; phase < 12; phase++)
        begin
            // counts stay inside the loaded slots, or reach or pass the whole table
            case ($urandom_range(7))
                0:       write_reg(REG_GROUP_COUNT, '0);
                1:       write_reg(REG_GROUP_COUNT, CNT_W'(1));
                2:       write_reg(REG_GROUP_COUNT, CNT_W'(2));
                3:       write_reg(REG_GROUP_COUNT, CNT_W'($urandom_range(3, 16)));
                4:       write_reg(REG_GROUP_COUNT, CNT_W'(LOADED));
                5:       write_reg(REG_GROUP_COUNT, CNT_W'(GROUPS));
                6:       write_reg(REG_GROUP_COUNT, CNT_W'($urandom_range(GROUPS + 1, 8191)));
                default: write_reg(REG_GROUP_COUNT, CNT_W'($urandom_range(1, LOADED)));
            endcase
            write_reg(REG_FUZZ_CHECK, CNT_W'($urandom));
            for (int k = 0; k < 50; k++)
            begin
                if ($urandom_range(99) < 10)
                begin
                    s = $urandom_range(LOADED - 1);
                    if ($urandom_range(99) < 70)
                    begin
                        // keep the table sorted around this slot
                        lo = (s == 0) ? 0 : start_tab[s-1];
                        hi = (s == LOADED - 1) ? ID_MAX : start_tab[s+1];
                        if (hi < lo)
                            hi = lo;
                        send_load(IDX_W'(s), ID_W'(lo + ($urandom % (hi - lo + 1))),
                                  pick_length());
                    end
                    else
                    begin
                        send_load(IDX_W'(s), ID_W'($urandom), ID_W'($urandom));
                    end
                end
                else
                begin
                    send_query(pick_member());
                end
                if ($urandom_range(99) < 2)
                    wait_drained();
            end
            wait_drained();
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_small_table();
        test_unsorted();
        test_full_table();
        test_hold_off();
        test_random();
        wait_drained();
        if (mismatch_count == 0 && expected_groups.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/mgil_pkg.sv
rtl/mgil_ctrl.sv
rtl/mgil_dp.sv
rtl/member_to_group_index_lookup.sv
rtl/mgil_checker.sv
sim/tb.sv
